// File: rtl/lfeb_pkg.sv
package lfeb_pkg;

    // Slot store geometry: the slot is the low bits of the event counter
    localparam int SLOTS       = 8192;
    localparam int SLOT_W      = 13;
    localparam int LANES_DEF   = 8;

    // Field widths
    localparam int EVN_W       = 32;
    localparam int LANE_W      = 3;
    localparam int BUF_W       = 13;
    localparam int LEN_W       = 17;
    localparam int MASK_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int KIND_W      = 2;
    localparam int CFG_W       = 4;

    // Slot entry: mask in the upper bits, fragment count in the lower bits
    localparam int SLOT_ENTRY_W = MASK_W + COUNT_W;
    // Fragment entry: buffer index in the upper bits, length in the lower bits
    localparam int FRAG_ENTRY_W = BUF_W + LEN_W;

    // Stream widths, packed from the lowest bit up and padded to whole bytes
    localparam int S_TDATA_W   = 80;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 56;
    localparam int M_TUSER_W   = KIND_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX          = 4'd15;
    localparam logic [CFG_W-1:0]   LANES_IN_USE_RESET = 4'd4;
    localparam logic [EVN_W-1:0]   LAST_COMPLETE_INIT = '1;

    // Input item function
    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETURN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [MASK_W-1:0] mask;
        logic              counter_gap;
        logic [LANE_W-1:0] returned_lane;
        logic [BUF_W-1:0]  returned_buffer;
        logic [LEN_W-1:0]  returned_length;
        logic              last;
    } result_t;

endpackage

// File: rtl/lfeb_ram.sv
module lfeb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lfeb_out_stage.sv
module lfeb_out_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  lfeb_pkg::result_t                   result,
    output logic                                free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lfeb_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [lfeb_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                m_tlast
);

    import lfeb_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Slot is free when empty or being taken this cycle
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {1'b0,
                       res_reg.returned_length,
                       res_reg.returned_buffer,
                       res_reg.returned_lane,
                       res_reg.counter_gap,
                       res_reg.mask,
                       res_reg.slot};

endmodule

// File: rtl/lane_fragment_event_builder.sv
// Event builder for up to LANES fragment lanes. An arrival item reads the event
// slot (mask and fragment count) from the slot memory when it is accepted, then,
// for a lane below LANES, writes it back together with the fragment's buffer
// index and length in the fragment memory; a completed event gives one result.
// A release item looks up and clears the slot, then for each returned buffer
// reads the fragment memory and gives one result from the registered read data;
// a release of an empty slot gives one result. A held result at m_tready low
// stalls an item that has a result to give. After reset the slot memory is
// swept clear, one entry a cycle, during which s_tready stays low; lanes_in_use
// writes are taken at any time.
module lane_fragment_event_builder #(
    parameter int LANES = lfeb_pkg::LANES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // event_number[31:0], arrival_lane[34:32], arrival_buffer[47:35],
    // arrival_length[64:48], release_slot[77:65], zero pad[79:78]
    input  logic [lfeb_pkg::S_TDATA_W-1:0]      s_tdata,
    // func[0]
    input  logic [lfeb_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // slot[12:0], mask[20:13], counter_gap[21], returned_lane[24:22],
    // returned_buffer[37:25], returned_length[54:38], zero pad[55]
    output logic [lfeb_pkg::M_TDATA_W-1:0]      m_tdata,
    // kind[1:0]
    output logic [lfeb_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lfeb_pkg::CFG_W-1:0]          cfg_data
);

    import lfeb_pkg::*;

    localparam int FRAG_DEPTH = SLOTS * LANES;
    localparam int FRAG_AW    = $clog2(FRAG_DEPTH);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_LOOKUP   = 3'd2;
    localparam logic [2:0] ST_WALK_RD  = 3'd3;
    localparam logic [2:0] ST_WALK_OUT = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [SLOT_W-1:0]  clear_idx_reg, clear_idx_next;
    logic [CFG_W-1:0]   lanes_in_use_reg;
    logic [EVN_W-1:0]   last_complete_reg, last_complete_next;
    logic [MASK_W-1:0]  rem_mask_reg, rem_mask_next;
    logic [MASK_W-1:0]  rel_mask_reg, rel_mask_next;
    logic [LANE_W-1:0]  walk_lane_reg, walk_lane_next;

    // Captured input item
    logic               func_reg;
    logic [EVN_W-1:0]   evn_reg;
    logic [LANE_W-1:0]  lane_reg;
    logic [BUF_W-1:0]   buf_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [SLOT_W-1:0]  slot_reg;

    logic               in_fire;
    logic               in_func;
    logic [EVN_W-1:0]   in_evn;
    logic [SLOT_W-1:0]  in_slot;

    // Memory ports
    logic                    slot_wr_en;
    logic [SLOT_W-1:0]       slot_wr_addr;
    logic [SLOT_ENTRY_W-1:0] slot_wr_data;
    logic [SLOT_ENTRY_W-1:0] slot_rd_data;
    logic                    frag_wr_en;
    logic [FRAG_AW-1:0]      frag_wr_addr;
    logic                    frag_rd_en;
    logic [FRAG_AW-1:0]      frag_rd_addr;
    logic [FRAG_ENTRY_W-1:0] frag_rd_data;

    // Lookup datapath
    logic [MASK_W-1:0]  old_mask, new_mask;
    logic [COUNT_W-1:0] stored_count, bumped_count;
    logic               lane_bad;
    logic               complete;
    logic               gap;
    logic [LANE_W-1:0]  low_lane;

    logic               out_free;
    logic               out_load;
    result_t            out_res;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_in_use_reg <= LANES_IN_USE_RESET;
        end
        else if (cfg_valid)
        begin
            lanes_in_use_reg <= cfg_data;
        end
    end

    // Unpack the input item
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_func  = s_tuser[0];
    assign in_evn   = s_tdata[31:0];
    assign in_slot  = (in_func == FUNC_RELEASE) ? s_tdata[77:65] : in_evn[SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= in_func;
            evn_reg  <= in_evn;
            lane_reg <= s_tdata[34:32];
            buf_reg  <= s_tdata[47:35];
            len_reg  <= s_tdata[64:48];
            slot_reg <= in_slot;
        end
    end

    // Slot entry update
    assign old_mask     = slot_rd_data[SLOT_ENTRY_W-1:COUNT_W];
    assign stored_count = slot_rd_data[COUNT_W-1:0];
    assign lane_bad     = {1'b0, lane_reg} >= (LANE_W + 1)'(LANES);
    assign new_mask     = old_mask | (MASK_W'(1) << lane_reg);
    assign bumped_count = (stored_count == COUNT_MAX) ? COUNT_MAX : stored_count + COUNT_W'(1);
    assign complete     = (bumped_count == lanes_in_use_reg);
    assign gap          = (evn_reg != EVN_W'(last_complete_reg + EVN_W'(1)));

    // Pick the lowest lane still to be returned
    always_comb
    begin
        low_lane = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (rem_mask_reg[i])
            begin
                low_lane = LANE_W'(i);
            end
        end
    end

    assign frag_wr_addr = FRAG_AW'(slot_reg) * FRAG_AW'(LANES) + FRAG_AW'(lane_reg);
    assign frag_rd_addr = FRAG_AW'(slot_reg) * FRAG_AW'(LANES) + FRAG_AW'(low_lane);

    // Sequencer
    always_comb
    begin
        state_next         = state_reg;
        clear_idx_next     = clear_idx_reg;
        last_complete_next = last_complete_reg;
        rem_mask_next      = rem_mask_reg;
        rel_mask_next      = rel_mask_reg;
        walk_lane_next     = walk_lane_reg;
        slot_wr_en         = 1'b0;
        slot_wr_addr       = slot_reg;
        slot_wr_data       = '0;
        frag_wr_en         = 1'b0;
        frag_rd_en         = 1'b0;
        out_load           = 1'b0;
        out_res            = '0;
        out_res.slot       = slot_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the slot memory to zero
                slot_wr_en     = 1'b1;
                slot_wr_addr   = clear_idx_reg;
                clear_idx_next = clear_idx_reg + SLOT_W'(1);
                if (clear_idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (func_reg == FUNC_ARRIVAL)
                begin
                    if (lane_bad)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!complete || out_free)
                    begin
                        // Store fragment and update slot
                        slot_wr_en   = 1'b1;
                        slot_wr_data = {new_mask, bumped_count};
                        frag_wr_en   = 1'b1;
                        state_next   = ST_IDLE;
                        if (complete)
                        begin
                            out_load            = 1'b1;
                            out_res.kind        = KIND_COMPLETE;
                            out_res.mask        = new_mask;
                            out_res.counter_gap = gap;
                            out_res.last        = 1'b1;
                            last_complete_next  = evn_reg;
                        end
                    end
                end
                else if (old_mask == '0)
                begin
                    if (out_free)
                    begin
                        slot_wr_en   = 1'b1;
                        out_load     = 1'b1;
                        out_res.kind = KIND_EMPTY;
                        out_res.last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    // Clear slot now, walk the captured mask
                    slot_wr_en    = 1'b1;
                    rem_mask_next = old_mask;
                    rel_mask_next = old_mask;
                    state_next    = ST_WALK_RD;
                end
            end
            ST_WALK_RD:
            begin
                frag_rd_en     = 1'b1;
                walk_lane_next = low_lane;
                rem_mask_next  = rem_mask_reg & ~(MASK_W'(1) << low_lane);
                state_next     = ST_WALK_OUT;
            end
            ST_WALK_OUT:
            begin
                if (out_free)
                begin
                    out_load                = 1'b1;
                    out_res.kind            = KIND_RETURN;
                    out_res.mask            = rel_mask_reg;
                    out_res.returned_lane   = walk_lane_reg;
                    out_res.returned_buffer = frag_rd_data[FRAG_ENTRY_W-1:LEN_W];
                    out_res.returned_length = frag_rd_data[LEN_W-1:0];
                    out_res.last            = (rem_mask_reg == '0);
                    state_next = (rem_mask_reg == '0) ? ST_IDLE : ST_WALK_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clear_idx_reg     <= '0;
            last_complete_reg <= LAST_COMPLETE_INIT;
            rem_mask_reg      <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            clear_idx_reg     <= clear_idx_next;
            last_complete_reg <= last_complete_next;
            rem_mask_reg      <= rem_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rel_mask_reg  <= rel_mask_next;
        walk_lane_reg <= walk_lane_next;
    end

    // Slot memory: mask and fragment count per slot
    lfeb_ram #(
        .WIDTH (SLOT_ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (in_fire),
        .rd_addr (in_slot),
        .rd_data (slot_rd_data)
    );

    // Fragment memory: buffer index and length per slot and lane
    lfeb_ram #(
        .WIDTH (FRAG_ENTRY_W),
        .DEPTH (FRAG_DEPTH)
    ) u_frag_ram (
        .clk     (clk),
        .wr_en   (frag_wr_en),
        .wr_addr (frag_wr_addr),
        .wr_data ({buf_reg, len_reg}),
        .rd_en   (frag_rd_en),
        .rd_addr (frag_rd_addr),
        .rd_data (frag_rd_data)
    );

    lfeb_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .result   (out_res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/lfeb_checker.sv
module lfeb_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [lfeb_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic [lfeb_pkg::M_TUSER_W-1:0]      m_tuser,
    input  logic                                m_tlast
);

    import lfeb_pkg::*;

    // Held result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("result changed while stalled");

    // One item at a time: no accept in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted during lookup");

    // Completion and empty release are single results
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_COMPLETE || m_tuser == KIND_EMPTY) |-> m_tlast)
    else $error("single result without last");

    // Empty release carries an empty mask
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_EMPTY |-> m_tdata[20:13] == '0)
    else $error("empty release with non-empty mask");

    // Returned lane is one of the mask's lanes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_RETURN |-> ((m_tdata[20:13] >> m_tdata[24:22]) & 8'd1) != 8'd0)
    else $error("returned lane not in mask");

endmodule

bind lane_fragment_event_builder lfeb_checker u_lfeb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);

// File: sim/tb_lane_fragment_event_builder.sv
`timescale 1ns / 100ps

module tb_lane_fragment_event_builder;

    import lfeb_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 9;
    // An arrival may give nothing back
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 16;
    // The clearing sweep after reset is the longest quiet stretch
    localparam int STALL_LIMIT   = 5 * SLOTS;
    localparam int PHASE_ITEMS   = 32;
    localparam int REPORT_MAX    = 10;

    // Result field offsets in m_tdata
    localparam int MASK_LO = SLOT_W;
    localparam int GAP_BIT = MASK_LO + MASK_W;
    localparam int LANE_LO = GAP_BIT + 1;
    localparam int BUF_LO  = LANE_LO + LANE_W;
    localparam int LEN_LO  = BUF_LO + BUF_W;

    typedef struct packed {
        logic              func;
        logic [EVN_W-1:0]  event_number;
        logic [LANE_W-1:0] lane;
        logic [BUF_W-1:0]  buffer_idx;
        logic [LEN_W-1:0]  frag_len;
        logic [SLOT_W-1:0] release_slot;
    } fragment_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // event_number, arrival_lane, arrival_buffer, arrival_length, release_slot, pad
    logic [S_TDATA_W-1:0] s_tdata;
    // func
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // slot, mask, counter_gap, returned_lane, returned_buffer, returned_length, pad
    logic [M_TDATA_W-1:0] m_tdata;
    // kind
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;

    // Local copy of the slot store and settings
    logic [MASK_W-1:0]    slot_mask     [SLOTS];
    logic [COUNT_W-1:0]   slot_count    [SLOTS];
    logic [BUF_W-1:0]     frag_buffer   [SLOTS * LANES_DEF];
    logic [LEN_W-1:0]     frag_length   [SLOTS * LANES_DEF];
    logic [EVN_W-1:0]     last_complete;
    logic [CFG_W-1:0]     lanes_in_use_now;
    logic [EVN_W-1:0]     next_event;

    result_t              results_due [$];
    int                   failures;
    int                   results_seen;
    int                   items_sent;
    int                   idle_cycles;
    int                   src_idle_pct;
    int                   snk_stall_pct;

    lane_fragment_event_builder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Fold one accepted item into the slot store and queue what it gives back
    task automatic apply_to_slot_store(input fragment_item_t it);
        logic [SLOT_W-1:0] s;
        logic [MASK_W-1:0] mask_now;
        int                pos;
        int                remaining;
        result_t           r;
        if (it.func == FUNC_ARRIVAL)
        begin
            s = SLOT_W'(it.event_number % SLOTS);
            pos = int'({s, it.lane});
            frag_buffer[pos] = it.buffer_idx;
            frag_length[pos] = it.frag_len;
            slot_mask[s] = slot_mask[s] | (MASK_W'(1) << it.lane);
            if (slot_count[s] != COUNT_MAX)
                slot_count[s] = slot_count[s] + COUNT_W'(1);
            if (slot_count[s] == lanes_in_use_now)
            begin
                r = '0;
                r.kind        = KIND_COMPLETE;
                r.slot        = s;
                r.mask        = slot_mask[s];
                r.counter_gap = (it.event_number != last_complete + 32'd1);
                r.last        = 1'b1;
                last_complete = it.event_number;
                results_due.insert(results_due.size(), r);
            end
        end
        else
        begin
            s = it.release_slot;
            mask_now = slot_mask[s];
            if (mask_now == '0)
            begin
                slot_count[s] = '0;
                r = '0;
                r.kind = KIND_EMPTY;
                r.slot = s;
                r.last = 1'b1;
                results_due.insert(results_due.size(), r);
            end
            else
            begin
                remaining = $countones(mask_now);
                // Walk the lanes from 0 upward
                for (int l = 0; l < LANES_DEF; l++)
                begin
                    if (mask_now[l])
                    begin
                        remaining--;
                        pos = int'({s, LANE_W'(l)});
                        r = '0;
                        r.kind            = KIND_RETURN;
                        r.slot            = s;
                        r.mask            = mask_now;
                        r.returned_lane   = LANE_W'(l);
                        r.returned_buffer = frag_buffer[pos];
                        r.returned_length = frag_length[pos];
                        r.last            = (remaining == 0);
                        results_due.insert(results_due.size(), r);
                    end
                end
                slot_mask[s]  = '0;
                slot_count[s] = '0;
            end
        end
    endtask

    task automatic note_failure(input string what);
        failures++;
        if (failures <= REPORT_MAX)
            $display("%s", what);
    endtask

    // Compare each returned item with the oldest one due
    task automatic check_returned_result();
        result_t got;
        result_t due;
        string   exp_txt;
        string   got_txt;
        got.kind            = m_tuser;
        got.slot            = m_tdata[SLOT_W-1:0];
        got.mask            = m_tdata[MASK_LO +: MASK_W];
        got.counter_gap     = m_tdata[GAP_BIT];
        got.returned_lane   = m_tdata[LANE_LO +: LANE_W];
        got.returned_buffer = m_tdata[BUF_LO +: BUF_W];
        got.returned_length = m_tdata[LEN_LO +: LEN_W];
        got.last            = m_tlast;
        results_seen++;
        if (results_due.size() == 0)
        begin
            note_failure($sformatf("result %0d arrived with nothing due: kind %0d slot %0d",
                                   results_seen, got.kind, got.slot));
        end
        else
        begin
            due = results_due.pop_front();
            if (got.kind != due.kind || got.slot != due.slot || got.mask != due.mask ||
                got.counter_gap != due.counter_gap ||
                got.returned_lane != due.returned_lane ||
                got.returned_buffer != due.returned_buffer ||
                got.returned_length != due.returned_length || got.last != due.last)
            begin
                exp_txt = $sformatf(
                    "exp kind %0d slot %0d mask %h gap %0d lane %0d buf %0d len %0d last %0d",
                    due.kind, due.slot, due.mask, due.counter_gap,
                    due.returned_lane, due.returned_buffer, due.returned_length, due.last);
                got_txt = $sformatf(
                    "got kind %0d slot %0d mask %h gap %0d lane %0d buf %0d len %0d last %0d",
                    got.kind, got.slot, got.mask, got.counter_gap,
                    got.returned_lane, got.returned_buffer, got.returned_length, got.last);
                note_failure($sformatf("result %0d mismatch:\n  %s\n  %s",
                                       results_seen, exp_txt, got_txt));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_returned_result();
    end

    // Stall the result side at the phase's rate
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Abort when nothing moves for too long
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Offer one item, with idle gaps at the phase's rate, and hold it until taken
    task automatic send_item(input fragment_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {2'b00, it.release_slot, it.frag_len, it.buffer_idx, it.lane,
                     it.event_number};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_to_slot_store(it);
        items_sent++;
    endtask

    function automatic fragment_item_t random_item();
        fragment_item_t it;
        it.func         = 1'($urandom_range(1));
        it.event_number = $urandom;
        it.lane         = LANE_W'($urandom_range(LANES_DEF - 1));
        it.buffer_idx   = BUF_W'($urandom);
        it.frag_len     = LEN_W'($urandom);
        it.release_slot = SLOT_W'($urandom_range(SLOTS - 1));
        return it;
    endfunction

    function automatic fragment_item_t arrival(input logic [EVN_W-1:0] evn,
                                               input logic [LANE_W-1:0] lane,
                                               input logic [BUF_W-1:0] bidx,
                                               input logic [LEN_W-1:0] len);
        fragment_item_t it;
        it = '0;
        it.func         = FUNC_ARRIVAL;
        it.event_number = evn;
        it.lane         = lane;
        it.buffer_idx   = bidx;
        it.frag_len     = len;
        return it;
    endfunction

    function automatic fragment_item_t release_of(input logic [SLOT_W-1:0] s);
        fragment_item_t it;
        it = '0;
        it.func         = FUNC_RELEASE;
        it.release_slot = s;
        return it;
    endfunction

    // Drop valid and let every due result come back, plus a settling pause
    task automatic wait_for_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_lanes_in_use(input logic [CFG_W-1:0] value);
        wait_for_quiet();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        lanes_in_use_now = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Fill one event, from distinct lanes in random order when it needs no more than LANES_DEF, then mostly free it
    task automatic send_event_burst();
        int unsigned       count;
        int unsigned       j;
        logic [LANE_W-1:0] lane_order [LANES_DEF];
        logic [LANE_W-1:0] tmp;
        logic [EVN_W-1:0]  evn;
        fragment_item_t    it;
        if (lanes_in_use_now == 0)
            count = $urandom_range(1, LANES_DEF);
        else if (lanes_in_use_now > LANES_DEF)
            count = lanes_in_use_now + $urandom_range(1);
        else if ($urandom_range(9) == 0)
            count = $urandom_range(1, lanes_in_use_now);
        else
            count = lanes_in_use_now;
        for (int i = 0; i < LANES_DEF; i++)
            lane_order[i] = LANE_W'(i);
        for (int i = LANES_DEF - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = lane_order[i];
            lane_order[i] = lane_order[j];
            lane_order[j] = tmp;
        end
        // Mostly the successor event, sometimes a jump
        evn = ($urandom_range(3) == 0) ? EVN_W'($urandom) : next_event;
        next_event = evn + 32'd1;
        for (int i = 0; i < count; i++)
        begin
            it = random_item();
            it.func         = FUNC_ARRIVAL;
            it.event_number = evn;
            it.lane = (count <= LANES_DEF) ? lane_order[i] : LANE_W'($urandom_range(7));
            send_item(it);
        end
        if ($urandom_range(4) != 0)
        begin
            it = random_item();
            it.func         = FUNC_RELEASE;
            it.release_slot = evn[SLOT_W-1:0];
            send_item(it);
        end
    endtask

    // Reset lane count, overwritten lane, field extremes, empty and top slot releases
    task automatic test_slot_defaults();
        send_item(arrival(32'd0, 3'd0, 13'd0, 17'd0));
        send_item(arrival(32'd0, 3'd7, 13'h1FFF, 17'h1FFFF));
        send_item(arrival(32'd0, 3'd7, 13'h0AAA, 17'h15555));
        send_item(arrival(32'd0, 3'd3, 13'h1555, 17'h0AAAA));
        send_item(release_of(13'd0));
        send_item(release_of(13'd0));
        send_item(release_of(13'h1FFF));
    endtask

    // Every lane in one event, eight buffers handed back
    task automatic test_all_lanes();
        set_lanes_in_use(4'd8);
        for (int l = LANES_DEF - 1; l >= 0; l--)
            send_item(arrival(32'd1, LANE_W'(l), BUF_W'($urandom), LEN_W'($urandom)));
        send_item(release_of(13'd1));
    endtask

    // Successor check across the 32-bit wrap, and a jump
    task automatic test_counter_wrap();
        set_lanes_in_use(4'd1);
        send_item(arrival(32'hFFFF_FFFF, 3'd2, 13'd17, 17'd100));
        send_item(arrival(32'd0, 3'd5, 13'd18, 17'd200));
        send_item(arrival(32'h7FFF_0005, 3'd1, 13'd19, 17'd300));
        send_item(release_of(13'h1FFF));
        send_item(release_of(13'd0));
        send_item(release_of(13'd5));
    endtask

    // Mostly whole events with random content, the rest stray items
    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input logic [CFG_W-1:0] lanes);
        int start;
        set_lanes_in_use(lanes);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            if ($urandom_range(9) < 7)
                send_event_burst();
            else
                send_item(random_item());
        end
        wait_for_quiet();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        failures      = 0;
        results_seen  = 0;
        items_sent    = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_mask[i]  = '0;
            slot_count[i] = '0;
        end
        last_complete    = LAST_COMPLETE_INIT;
        lanes_in_use_now = LANES_IN_USE_RESET;
        next_event       = $urandom;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_slot_defaults();
        test_all_lanes();
        test_counter_wrap();
        test_random_traffic(0, 0, 4'd3);
        test_random_traffic(81, 0, 4'd15);
        test_random_traffic(0, 81, 4'd0);
        test_random_traffic(12, 12, 4'd6);

        wait_for_quiet();
        repeat (END_CYCLES) @(posedge clk);
        if (results_due.size() != 0)
            note_failure($sformatf("%0d results never arrived", results_due.size()));
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: lane_fragment_event_builder.f
rtl/lfeb_pkg.sv
rtl/lfeb_ram.sv
rtl/lfeb_out_stage.sv
rtl/lane_fragment_event_builder.sv
rtl/lfeb_checker.sv
sim/tb_lane_fragment_event_builder.sv
